### design/cba_pkg.sv
`default_nettype none

package cba_pkg;

    // Sizing
    localparam int BLOCK_MAX   = 1024;
    localparam int AVERAGE_MAX = 256;
    localparam int SAMPLE_W    = 16;

    localparam int POS_W    = $clog2(BLOCK_MAX);      // position within a block
    localparam int BSIZE_W  = POS_W + 1;               // block_size register
    localparam int BCNT_W   = $clog2(AVERAGE_MAX);    // block within a group
    localparam int NAVG_W   = BCNT_W + 1;              // num_to_average register
    localparam int ACC_W    = SAMPLE_W + BCNT_W;       // per-position sum
    localparam int TDATA_W  = 2 * SAMPLE_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BSIZE_W;
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_TO_AVERAGE = 1'b0,
        REG_BLOCK_SIZE     = 1'b1
    } cfg_reg_t;

    // One classified sample on its way from the front to the back
    typedef struct packed {
        logic [POS_W-1:0]           pos;
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       first;   // first block of a group: overwrite
        logic                       emit;    // last block of a group: produce a result
        logic                       last;    // final position of the block
    } cba_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_START,
        ST_DIV,
        ST_OUT
    } back_state_t;

endpackage : cba_pkg

`default_nettype wire

### design/cba_front.sv
`default_nettype none

module cba_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [cba_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [cba_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [cba_pkg::TDATA_W-1:0]    s_tdata,
    input  wire logic                           q_full,
    output logic                                q_push,
    output cba_pkg::cba_item_t                  q_item,
    output logic [cba_pkg::NAVG_W-1:0]          eff_navg
);
    import cba_pkg::*;

    logic [NAVG_W-1:0]  num_avg_reg, num_avg_next;
    logic [BSIZE_W-1:0] blk_size_reg, blk_size_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [BCNT_W-1:0]  bcnt_reg, bcnt_next;

    logic [BSIZE_W-1:0] eff_bs;
    logic [POS_W-1:0]   pos_cur;
    logic [BSIZE_W-1:0] pos_inc;
    logic [NAVG_W-1:0]  bcnt_inc;
    logic               emit;
    logic               accept;

    // Clamp registers into their working range
    always_comb
    begin
        if (num_avg_reg == '0)
            eff_navg = NAVG_W'(1);
        else if (num_avg_reg > NAVG_W'(AVERAGE_MAX))
            eff_navg = NAVG_W'(AVERAGE_MAX);
        else
            eff_navg = num_avg_reg;

        if (blk_size_reg == '0)
            eff_bs = BSIZE_W'(1);
        else if (blk_size_reg > BSIZE_W'(BLOCK_MAX))
            eff_bs = BSIZE_W'(BLOCK_MAX);
        else
            eff_bs = blk_size_reg;
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign q_push   = accept;

    assign pos_cur  = ({1'b0, pos_reg} >= eff_bs) ? '0 : pos_reg;
    assign pos_inc  = {1'b0, pos_cur} + BSIZE_W'(1);
    assign bcnt_inc = {1'b0, bcnt_reg} + NAVG_W'(1);
    assign emit     = (bcnt_inc >= eff_navg);

    always_comb
    begin
        q_item.pos   = pos_cur;
        q_item.re    = s_tdata[SAMPLE_W-1:0];
        q_item.im    = s_tdata[TDATA_W-1:SAMPLE_W];
        q_item.first = (bcnt_reg == '0);
        q_item.emit  = emit;
        q_item.last  = (pos_inc == eff_bs);
    end

    // Counters and registers; any register write restarts the group
    always_comb
    begin
        num_avg_next  = num_avg_reg;
        blk_size_next = blk_size_reg;
        pos_next      = pos_reg;
        bcnt_next     = bcnt_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_NUM_TO_AVERAGE: num_avg_next  = cfg_wdata[NAVG_W-1:0];
                REG_BLOCK_SIZE:     blk_size_next = cfg_wdata;
                default:            num_avg_next  = num_avg_reg;
            endcase
            pos_next  = '0;
            bcnt_next = '0;
        end
        else if (accept)
        begin
            if (pos_inc >= eff_bs)
            begin
                pos_next  = '0;
                bcnt_next = emit ? '0 : bcnt_inc[BCNT_W-1:0];
            end
            else
            begin
                pos_next = pos_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_avg_reg  <= NAVG_W'(8);
            blk_size_reg <= BSIZE_W'(1);
            pos_reg      <= '0;
            bcnt_reg     <= '0;
        end
        else
        begin
            num_avg_reg  <= num_avg_next;
            blk_size_reg <= blk_size_next;
            pos_reg      <= pos_next;
            bcnt_reg     <= bcnt_next;
        end
    end

endmodule : cba_front

`default_nettype wire

### design/cba_queue.sv
`default_nettype none

module cba_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire cba_pkg::cba_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output cba_pkg::cba_item_t      head,
    output logic                    empty
);
    import cba_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cba_item_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule : cba_queue

`default_nettype wire

### design/cba_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, real and imaginary lanes together.
module cba_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [cba_pkg::ACC_W-1:0]  num_re,
    input  wire logic signed [cba_pkg::ACC_W-1:0]  num_im,
    input  wire logic [cba_pkg::NAVG_W-1:0]        den,
    output logic                                   done,
    output logic signed [cba_pkg::SAMPLE_W-1:0]    quo_re,
    output logic signed [cba_pkg::SAMPLE_W-1:0]    quo_im
);
    import cba_pkg::*;

    localparam int CNT_W = $clog2(ACC_W);
    localparam int REM_W = NAVG_W - 1;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [NAVG_W-1:0]  den_reg;
    logic [ACC_W-1:0]   dvd_re_reg, dvd_re_next, dvd_im_reg, dvd_im_next;
    logic [REM_W-1:0]   rem_re_reg, rem_re_next, rem_im_reg, rem_im_next;
    logic               neg_re_reg, neg_im_reg;
    logic [ACC_W-1:0]   res_re, res_im;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    function automatic logic [REM_W+ACC_W-1:0] div_step(
        input logic [REM_W-1:0]  rem,
        input logic [ACC_W-1:0]  dvd,
        input logic [NAVG_W-1:0] d
    );
        logic [NAVG_W-1:0] trial;
        logic [REM_W-1:0]  rem_o;
        logic              qbit;
        trial = {rem, dvd[ACC_W-1]};
        qbit  = (trial >= d);
        rem_o = qbit ? REM_W'(trial - d) : trial[REM_W-1:0];
        return {rem_o, dvd[ACC_W-2:0], qbit};
    endfunction

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        dvd_re_next = dvd_re_reg;
        dvd_im_next = dvd_im_reg;
        rem_re_next = rem_re_reg;
        rem_im_next = rem_im_reg;
        if (busy_reg)
        begin
            {rem_re_next, dvd_re_next} = div_step(rem_re_reg, dvd_re_reg, den_reg);
            {rem_im_next, dvd_im_next} = div_step(rem_im_reg, dvd_im_reg, den_reg);
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(ACC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg    <= den;
            neg_re_reg <= num_re[ACC_W-1];
            neg_im_reg <= num_im[ACC_W-1];
            dvd_re_reg <= num_re[ACC_W-1] ? -num_re : num_re;
            dvd_im_reg <= num_im[ACC_W-1] ? -num_im : num_im;
            rem_re_reg <= '0;
            rem_im_reg <= '0;
        end
        else
        begin
            dvd_re_reg <= dvd_re_next;
            dvd_im_reg <= dvd_im_next;
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
        end
    end

    // Restore the sign; the quotient always fits the sample width
    assign res_re = neg_re_reg ? -dvd_re_reg : dvd_re_reg;
    assign res_im = neg_im_reg ? -dvd_im_reg : dvd_im_reg;
    assign quo_re = res_re[SAMPLE_W-1:0];
    assign quo_im = res_im[SAMPLE_W-1:0];
    assign done   = done_reg;

endmodule : cba_div

`default_nettype wire

### design/cba_back.sv
`default_nettype none

module cba_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cba_pkg::cba_item_t             q_head,
    input  wire logic                           q_empty,
    output logic                                q_pop,
    input  wire logic [cba_pkg::NAVG_W-1:0]     eff_navg,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [cba_pkg::TDATA_W-1:0]         m_tdata,
    output logic                                m_tlast
);
    import cba_pkg::*;

    back_state_t state_reg, state_next;

    // Accumulator store: {imag, real} per position, never cleared
    logic [2*ACC_W-1:0] acc_mem [BLOCK_MAX];
    logic [2*ACC_W-1:0] rd_data_reg;

    cba_item_t                item_reg;
    logic signed [ACC_W-1:0]  sum_re_reg, sum_im_reg;
    logic signed [ACC_W-1:0]  sum_re, sum_im;
    logic signed [ACC_W-1:0]  base_re, base_im;

    logic                     out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]      out_re_reg, out_im_reg;
    logic                     out_last_reg;

    logic                     rd_en, wr_en, div_start, out_load;
    logic                     div_done;
    logic signed [SAMPLE_W-1:0] quo_re, quo_im;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (!q_empty) state_next = ST_ACC;
            ST_ACC:   state_next = item_reg.emit ? ST_START : ST_IDLE;
            ST_START: state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_OUT;
            ST_OUT:   if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        q_pop     = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop = !q_empty;
                rd_en = !q_empty;
            end
            ST_ACC:   wr_en     = 1'b1;
            ST_START: div_start = 1'b1;
            ST_DIV:   out_load  = 1'b0;
            ST_OUT:   out_load  = !out_valid_reg || m_tready;
            default:  out_load  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // First block of a group overwrites, later blocks add
    assign base_re = item_reg.first ? '0 : rd_data_reg[ACC_W-1:0];
    assign base_im = item_reg.first ? '0 : rd_data_reg[2*ACC_W-1:ACC_W];
    assign sum_re  = base_re + ACC_W'(item_reg.re);
    assign sum_im  = base_im + ACC_W'(item_reg.im);

    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_head;
        if (wr_en)
        begin
            sum_re_reg <= sum_re;
            sum_im_reg <= sum_im;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= acc_mem[q_head.pos];
        if (wr_en)
            acc_mem[item_reg.pos] <= {sum_im, sum_re};
    end

    cba_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_re (sum_re_reg),
        .num_im (sum_im_reg),
        .den    (eff_navg),
        .done   (div_done),
        .quo_re (quo_re),
        .quo_im (quo_im)
    );

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_re_reg   <= quo_re;
            out_im_reg   <= quo_im;
            out_last_reg <= item_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_im_reg, out_re_reg};
    assign m_tlast  = out_last_reg;

endmodule : cba_back

`default_nettype wire

### design/complex_block_average_core.sv
`default_nettype none

// Channel   Dir  Signals                       Contents (lowest bit up)
// -------   ---  ----------------------------  ----------------------------------
// s_*       in   s_tvalid s_tready s_tdata     sample_re[15:0], sample_im[31:16]
// m_*       out  m_tvalid m_tready m_tdata     avg_re[15:0], avg_im[31:16]
//                m_tlast                       last_of_block
// cfg_*     in   cfg_we cfg_addr cfg_wdata     0: num_to_average, 1: block_size
//
// Back end steps: a request that ends no group goes through a memory read, then
// accumulate and write back. One in the last block of a group also launches the
// divider, runs its one-bit-per-cycle restoring loop and done flag, and then
// loads the output register.
// The accumulator memory port (one read or one write a cycle) and the serial
// divider set this pace. A two-entry queue lets the input side keep taking
// requests while the back end works or a result waits downstream.
// Reset clears counters, queue, sequencer and output valid; the accumulators are
// not cleared, since the first block of each group overwrites them.
// Hold a result on m_tdata while m_tready is low; s_tready drops when the queue fills.
module complex_block_average_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [cba_pkg::TDATA_W-1:0]    s_tdata,   // sample_re, sample_im
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [cba_pkg::TDATA_W-1:0]         m_tdata,   // avg_re, avg_im
    output logic                                m_tlast,
    input  wire logic                           cfg_we,
    input  wire logic [cba_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [cba_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import cba_pkg::*;

    cba_item_t          push_item;
    cba_item_t          head_item;
    logic               q_push, q_full, q_pop, q_empty;
    logic [NAVG_W-1:0]  eff_navg;

    // Front: take requests, track position and block, classify each sample
    cba_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item),
        .eff_navg  (eff_navg)
    );

    // Queue: decouple the two sides
    cba_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (head_item),
        .empty     (q_empty)
    );

    // Back: accumulate per position, divide on the last block, drive results
    cba_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_head   (head_item),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .eff_navg (eff_navg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule : complex_block_average_core

`default_nettype wire

### design/cba_chk.sv
`default_nettype none

module cba_chk (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [cba_pkg::TDATA_W-1:0]    m_tdata,
    input wire logic                           m_tlast
);
    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Out of reset the queue is empty and no result is pending
    a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> s_tready && !m_tvalid)
        else $error("bad state after reset");

    // The queue fills only through an accepted request
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("s_tready dropped without a request");

endmodule : cba_chk

bind complex_block_average_core cba_chk u_cba_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
